>>> design/fci_pkg.sv
// shared types and constants for the fan curve interpolator
package fci_pkg;

   localparam int NUM_PT_REGS     = 6;
   localparam int MAX_POINTS_DEF  = 6;
   localparam int PADDR_W         = 5;
   localparam int PDATA_W         = 32;
   localparam int DIVIDEND_W      = 15;
   localparam int DIVISOR_W       = 8;

   localparam logic [6:0] DUTY_FULL = 7'd100;

   // register indexes
   localparam logic [2:0] REG_POINT_COUNT = 3'd6;
   localparam logic [2:0] REG_HYSTERESIS  = 3'd7;

   // reset values of the curve registers
   localparam logic [15:0] POINT_0_RST = 16'd10270;
   localparam logic [15:0] POINT_1_RST = 16'd15405;
   localparam logic [15:0] POINT_2_RST = 16'd19265;
   localparam logic [15:0] POINT_3_RST = 16'd21845;
   localparam logic [15:0] POINT_4_RST = 16'd24420;
   localparam logic [15:0] POINT_5_RST = 16'd0;
   localparam logic [2:0]  POINT_COUNT_RST = 3'd5;
   localparam logic [4:0]  HYSTERESIS_RST  = 5'd3;

   typedef struct packed {
      logic signed [7:0] temperature;
      logic              falling_edge;
   } req_type;

   typedef struct packed {
      logic [6:0] duty_percent;
      logic       curve_valid;
   } rsp_type;

   typedef struct packed {
      logic [NUM_PT_REGS-1:0][15:0] point;
      logic [2:0]                   point_count;
      logic [4:0]                   hysteresis;
   } cfg_type;

endpackage

>>> design/fci_regs.sv
// apb configuration registers holding the fan curve
module fci_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fci_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [fci_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [fci_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output fci_pkg::cfg_type              cfg
);

   logic [fci_pkg::NUM_PT_REGS-1:0][15:0] point_ff, point_in;
   logic [2:0] count_ff, count_in;
   logic [4:0] hyst_ff, hyst_in;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      point_in = point_ff;
      count_in = count_ff;
      hyst_in  = hyst_ff;
      if (wr_en) begin
         priority if (idx == fci_pkg::REG_POINT_COUNT) begin
            count_in = csr_pwdata[2:0];
         end else if (idx == fci_pkg::REG_HYSTERESIS) begin
            hyst_in = csr_pwdata[4:0];
         end else begin
            point_in[idx] = csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      priority if (idx == fci_pkg::REG_POINT_COUNT) begin
         csr_prdata = {29'd0, count_ff};
      end else if (idx == fci_pkg::REG_HYSTERESIS) begin
         csr_prdata = {27'd0, hyst_ff};
      end else begin
         csr_prdata = {16'd0, point_ff[idx]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff[0] <= fci_pkg::POINT_0_RST;
         point_ff[1] <= fci_pkg::POINT_1_RST;
         point_ff[2] <= fci_pkg::POINT_2_RST;
         point_ff[3] <= fci_pkg::POINT_3_RST;
         point_ff[4] <= fci_pkg::POINT_4_RST;
         point_ff[5] <= fci_pkg::POINT_5_RST;
         count_ff    <= fci_pkg::POINT_COUNT_RST;
         hyst_ff     <= fci_pkg::HYSTERESIS_RST;
      end else begin
         point_ff <= point_in;
         count_ff <= count_in;
         hyst_ff  <= hyst_in;
      end
   end

   assign cfg.point       = point_ff;
   assign cfg.point_count = count_ff;
   assign cfg.hysteresis  = hyst_ff;

endmodule

>>> design/fci_div.sv
// serial restoring divider, one quotient bit per cycle
module fci_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [fci_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [fci_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             done,
   output logic [fci_pkg::DIVIDEND_W-1:0]   quotient
);

   localparam int DW = fci_pkg::DIVIDEND_W;
   localparam int VW = fci_pkg::DIVISOR_W;
   localparam int CW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dvs_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? VW'(shifted - {1'b0, dvs_ff}) : shifted[VW-1:0];
         quo_in   = {quo_ff[DW-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/fci_core.sv
// sequencer: curve scan, segment setup, multiply and result assembly
module fci_core #(
   parameter int MAX_POINTS = fci_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fci_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fci_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fci_pkg::rsp_type                rsp_data,
   output logic                            div_start,
   output logic [fci_pkg::DIVIDEND_W-1:0]  div_dividend,
   output logic [fci_pkg::DIVISOR_W-1:0]   div_divisor,
   input  logic                            div_done,
   input  logic [fci_pkg::DIVIDEND_W-1:0]  div_quotient
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIVGO = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        k_ff, k_in;
   logic signed [8:0] t_ff, t_in;
   logic              bad_ff, bad_in;
   logic              found_ff, found_in;
   logic              clamp_ff, clamp_in;
   logic signed [7:0] prev_temp_ff, prev_temp_in;
   logic [6:0]        prev_pct_ff, prev_pct_in;
   logic [7:0]        dx_ff, dx_in;
   logic signed [7:0] dy_ff, dy_in;
   logic [6:0]        p0_ff, p0_in;
   logic [7:0]        span_ff, span_in;
   logic [6:0]        duty_ff, duty_in;
   logic              neg_ff, neg_in;
   logic [14:0]       mag_ff, mag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fci_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic              accept;
   logic signed [7:0] cur_temp;
   logic [6:0]        cur_pct;
   logic              cur_bad;
   logic [2:0]        last_k;
   logic signed [8:0] hyst_s;
   logic signed [16:0] prod;
   logic signed [16:0] num;
   logic [8:0]        q9;
   logic [8:0]        sum9;
   logic              out_free;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign cur_temp  = $signed(cfg.point[k_ff][15:8]);
   assign cur_pct   = cfg.point[k_ff][6:0];
   assign cur_bad   = (cur_pct > fci_pkg::DUTY_FULL) ||
                      ((k_ff != 3'd0) && (cur_temp <= prev_temp_ff));
   assign last_k    = cfg.point_count - 3'd1;
   assign hyst_s    = $signed({4'd0, cfg.hysteresis});
   assign prod      = dy_ff * $signed({1'b0, span_ff});
   assign num       = prod + $signed({10'd0, dx_ff[7:1]});
   assign q9        = div_quotient[8:0];
   assign sum9      = {2'd0, p0_ff} + (neg_ff ? 9'(-q9) : q9);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign div_start    = state_ff == S_DIVGO;
   assign div_dividend = mag_ff;
   assign div_divisor  = dx_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      bad_in       = bad_ff;
      found_in     = found_ff;
      clamp_in     = clamp_ff;
      prev_temp_in = prev_temp_ff;
      prev_pct_in  = prev_pct_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      p0_in        = p0_ff;
      span_in      = span_ff;
      duty_in      = duty_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               t_in     = req_data.falling_edge ?
                          ({req_data.temperature[7], req_data.temperature} - hyst_s) :
                          {req_data.temperature[7], req_data.temperature};
               k_in     = 3'd0;
               found_in = 1'b0;
               clamp_in = 1'b0;
               bad_in   = (cfg.point_count < 3'd2) ||
                          (cfg.point_count > 3'(MAX_POINTS));
               state_in = bad_in ? S_OUT : S_SCAN;
            end
         end
         S_SCAN: begin
            bad_in = bad_ff | cur_bad;
            if (!found_ff) begin
               if (t_ff <= $signed({cur_temp[7], cur_temp})) begin
                  found_in = 1'b1;
                  if (k_ff == 3'd0) begin
                     clamp_in = 1'b1;
                     duty_in  = cur_pct;
                  end else begin
                     dx_in   = 8'(cur_temp - prev_temp_ff);
                     dy_in   = $signed({1'b0, cur_pct}) - $signed({1'b0, prev_pct_ff});
                     p0_in   = prev_pct_ff;
                     span_in = 8'(t_ff - {prev_temp_ff[7], prev_temp_ff});
                  end
               end else begin
                  // past this point so far: last percent unless a later segment hits
                  duty_in = cur_pct;
               end
            end
            prev_temp_in = cur_temp;
            prev_pct_in  = cur_pct;
            k_in         = k_ff + 3'd1;
            if (k_ff == last_k) begin
               state_in = (bad_in || !found_in || clamp_in) ? S_OUT : S_MUL;
            end
         end
         S_MUL: begin
            neg_in   = num[16];
            mag_in   = num[16] ? 15'(-num) : num[14:0];
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               duty_in  = sum9[6:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.duty_percent = bad_ff ? fci_pkg::DUTY_FULL : duty_ff;
               rsp_data_in.curve_valid  = ~bad_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      t_ff         <= t_in;
      bad_ff       <= bad_in;
      found_ff     <= found_in;
      clamp_ff     <= clamp_in;
      prev_temp_ff <= prev_temp_in;
      prev_pct_ff  <= prev_pct_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      p0_ff        <= p0_in;
      span_ff      <= span_in;
      duty_ff      <= duty_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/fan_curve_interpolator_top.sv
// fan curve interpolator: piecewise linear duty lookup with hysteresis
// sequence: accept, a scan over every curve point, multiply, divider start and divide,
// then output when interpolating; when clamped or past the last point the scan goes
// straight to output, and a bad point count goes from accept straight to output
// throughput: one request at a time; the next is taken while a result waits to be read
// reset: synchronous, curve registers return to their default curve, block idle
module fan_curve_interpolator_top #(
   parameter int MAX_POINTS = fci_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fci_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fci_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fci_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [fci_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [fci_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);

   fci_pkg::cfg_type                 cfg;
   logic                             div_start;
   logic [fci_pkg::DIVIDEND_W-1:0]   div_dividend;
   logic [fci_pkg::DIVISOR_W-1:0]    div_divisor;
   logic                             div_done;
   logic [fci_pkg::DIVIDEND_W-1:0]   div_quotient;

   fci_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fci_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   fci_core #(
      .MAX_POINTS (MAX_POINTS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

endmodule

>>> dv/tb_fan_curve_interpolator_top.sv
// testbench for the fan curve interpolator: curve programming, duty checks, stalls
`timescale 1ns / 100ps

// holds a shadow copy of the curve and the queue of duties still due from the block
class duty_scoreboard;
   logic [15:0]      point [fci_pkg::NUM_PT_REGS];
   logic [2:0]       count;
   logic [4:0]       hyst;
   fci_pkg::rsp_type duty_q [$];
   int               errors;

   function new();
      point[0] = fci_pkg::POINT_0_RST;
      point[1] = fci_pkg::POINT_1_RST;
      point[2] = fci_pkg::POINT_2_RST;
      point[3] = fci_pkg::POINT_3_RST;
      point[4] = fci_pkg::POINT_4_RST;
      point[5] = fci_pkg::POINT_5_RST;
      count    = fci_pkg::POINT_COUNT_RST;
      hyst     = fci_pkg::HYSTERESIS_RST;
      errors   = 0;
   endfunction

   function void write_reg(int idx, logic [31:0] value);
      if (idx == fci_pkg::REG_POINT_COUNT) begin
         count = value[2:0];
      end else if (idx == fci_pkg::REG_HYSTERESIS) begin
         hyst = value[4:0];
      end else if (idx < fci_pkg::NUM_PT_REGS) begin
         point[idx] = value[15:0];
      end
   endfunction

   function int temp_of(int k);
      return int'($signed(point[k][15:8]));
   endfunction

   function int pct_of(int k);
      return int'(point[k][6:0]);
   endfunction

   function bit curve_ok();
      int n;
      n = count;
      if (n < 2 || n > fci_pkg::MAX_POINTS_DEF) return 1'b0;
      for (int k = 0; k < n; k++) begin
         if (pct_of(k) > int'(fci_pkg::DUTY_FULL)) return 1'b0;
         if (k > 0 && temp_of(k) <= temp_of(k - 1)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function fci_pkg::rsp_type predict_duty(fci_pkg::req_type r);
      fci_pkg::rsp_type e;
      int t, n, x0, dx, dy, duty;
      bit ok;
      bit found;
      ok    = curve_ok();
      n     = count;
      duty  = int'(fci_pkg::DUTY_FULL);
      found = 1'b0;
      if (ok) begin
         t = int'(r.temperature);
         if (r.falling_edge) t = t - int'(hyst);
         duty = pct_of(n - 1);
         if (t <= temp_of(0)) begin
            duty = pct_of(0);
         end else begin
            for (int k = 1; k < n; k++) begin
               if (!found && t <= temp_of(k)) begin
                  x0    = temp_of(k - 1);
                  dx    = temp_of(k) - x0;
                  dy    = pct_of(k) - pct_of(k - 1);
                  // int division truncates toward zero, as the block does
                  duty  = pct_of(k - 1) + (dy * (t - x0) + dx / 2) / dx;
                  found = 1'b1;
               end
            end
         end
      end
      e.duty_percent = duty[6:0];
      e.curve_valid  = ok;
      return e;
   endfunction

   function void note_request(fci_pkg::req_type r);
      duty_q.push_back(predict_duty(r));
   endfunction

   function void check_result(fci_pkg::rsp_type got);
      fci_pkg::rsp_type want;
      if (duty_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected result duty=%0d valid=%0b", $realtime,
                     got.duty_percent, got.curve_valid);
         return;
      end
      want = duty_q.pop_front();
      if (got.duty_percent !== want.duty_percent || got.curve_valid !== want.curve_valid) begin
         errors++;
         if (errors <= 10)
            $display("%0t: mismatch duty exp=%0d act=%0d, valid exp=%0b act=%0b", $realtime,
                     want.duty_percent, got.duty_percent, want.curve_valid, got.curve_valid);
      end
   endfunction

   function int pending();
      return duty_q.size();
   endfunction

   function void check_drained();
      if (duty_q.size() != 0) begin
         errors++;
         $display("%0t: %0d expected results never arrived", $realtime, duty_q.size());
      end
   endfunction
endclass

module tb_fan_curve_interpolator_top;

   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_ITEMS      = 31;
   // point register reworked by the invalid curve checks
   localparam int EDIT_POINT       = 3;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   fci_pkg::req_type             req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   fci_pkg::rsp_type             rsp_data;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [fci_pkg::PADDR_W-1:0]  csr_paddr;
   logic [fci_pkg::PDATA_W-1:0]  csr_pwdata;
   logic [fci_pkg::PDATA_W-1:0]  csr_prdata;
   logic                         csr_pready;

   duty_scoreboard      book;
   bit                  long_hold = 1'b0;

   fan_curve_interpolator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.note_request(req_data);
         if (rsp_valid && !rsp_stall) book.check_result(rsp_data);
      end
   end

   // receiver stall pattern, with an occasional long hold-off on request
   initial begin : rsp_stall_gen
      int seg_len;
      int pct;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            seg_len = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
               0: pct = 0;
               1: pct = 40;
               default: pct = 85;
            endcase
            repeat (seg_len) begin
               rsp_stall <= ($urandom_range(0, 99) < pct);
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic fci_pkg::req_type mk_req(int t, bit fall);
      fci_pkg::req_type r;
      r.temperature  = t[7:0];
      r.falling_edge = fall;
      return r;
   endfunction

   function automatic logic [15:0] pack_point(int t, int pct, bit b7);
      return {t[7:0], b7, pct[6:0]};
   endfunction

   // readings cluster around the curve points so every segment gets exercised
   function automatic fci_pkg::req_type pick_reading();
      fci_pkg::req_type r;
      int               k;
      int               t;
      r.falling_edge = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 6 && book.count >= 1 && book.count <= fci_pkg::NUM_PT_REGS)
      begin
         k = $urandom_range(0, book.count - 1);
         t = book.temp_of(k) + int'($urandom_range(0, 8)) - 4;
         if (r.falling_edge) t = t + int'(book.hyst);
         if (t > 127) t = 127;
         if (t < -128) t = -128;
         r.temperature = t[7:0];
      end else begin
         r.temperature = 8'($urandom_range(0, 255));
      end
      return r;
   endfunction

   task automatic send_request(fci_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= fci_pkg::PADDR_W'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_curve(logic [15:0] pts [fci_pkg::NUM_PT_REGS], int cnt, int hy);
      for (int k = 0; k < fci_pkg::NUM_PT_REGS; k++) csr_write(k, {16'h0, pts[k]});
      csr_write(fci_pkg::REG_POINT_COUNT, {29'h0, cnt[2:0]});
      csr_write(fci_pkg::REG_HYSTERESIS, {27'h0, hy[4:0]});
   endtask

   // mostly valid curves; now and then one broken in a random way
   task automatic program_random_curve();
      logic [15:0] pts [fci_pkg::NUM_PT_REGS];
      logic [15:0] swap;
      int          n, t, step_max, k;
      n = $urandom_range(2, 6);
      t = int'($urandom_range(0, 120)) - 128;
      for (k = 0; k < fci_pkg::NUM_PT_REGS; k++) begin
         if (k < n) begin
            pts[k] = pack_point(t, $urandom_range(0, 100), 1'($urandom_range(0, 1)));
            if (k < n - 1) begin
               step_max = (127 - t) / (n - 1 - k);
               if (step_max < 1) step_max = 1;
               t = t + (($urandom_range(0, 3) == 0) ? 1 : int'($urandom_range(1, step_max)));
            end
         end else begin
            pts[k] = 16'($urandom_range(0, 65535));
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: n = $urandom_range(0, 1);
            1: n = 7;
            2: pts[$urandom_range(0, n - 1)][6:0] = 7'($urandom_range(101, 127));
            default: begin
               k = $urandom_range(1, n - 1);
               if ($urandom_range(0, 1)) begin
                  swap       = pts[k];
                  pts[k]     = pts[k - 1];
                  pts[k - 1] = swap;
               end else begin
                  pts[k][15:8] = pts[k - 1][15:8];
               end
            end
         endcase
      end
      program_curve(pts, n, $urandom_range(0, 31));
   endtask

   task automatic run_random(int items);
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 16);
      for (int i = 0; i < items; i++) begin
         send_request(pick_reading());
         burst_left--;
         if (burst_left == 0 && i < items - 1) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 30));
            if (gap > 0) idle_sender(gap);
            burst_left = $urandom_range(1, 16);
         end
      end
      idle_sender(1);
   endtask

   initial begin : stimulus
      logic [15:0] pts [fci_pkg::NUM_PT_REGS];
      int          waited;
      book        = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default curve out of reset: clamps at both ends, interpolation, hysteresis
      send_request(mk_req(-128, 1'b0));
      send_request(mk_req(127, 1'b0));
      send_request(mk_req(40, 1'b0));
      send_request(mk_req(41, 1'b0));
      send_request(mk_req(50, 1'b0));
      send_request(mk_req(60, 1'b0));
      send_request(mk_req(96, 1'b0));
      send_request(mk_req(43, 1'b1));
      send_request(mk_req(-1, 1'b1));
      send_request(mk_req(0, 1'b1));
      idle_sender(1);
      wait_drained();

      // six points spanning the full range, falling slopes, max hysteresis
      pts[0] = pack_point(-128, 0, 1'b0);
      pts[1] = pack_point(-60, 100, 1'b1);
      pts[2] = pack_point(0, 37, 1'b0);
      pts[3] = pack_point(1, 38, 1'b1);
      pts[4] = pack_point(50, 0, 1'b0);
      pts[5] = pack_point(127, 100, 1'b0);
      program_curve(pts, 6, 31);
      send_request(mk_req(-128, 1'b1));
      send_request(mk_req(-127, 1'b0));
      send_request(mk_req(-29, 1'b1));
      send_request(mk_req(0, 1'b0));
      send_request(mk_req(126, 1'b1));
      send_request(mk_req(127, 1'b0));
      idle_sender(1);
      wait_drained();

      // two points, widest span, no hysteresis; unused points carry junk
      pts[0] = pack_point(-128, 100, 1'b0);
      pts[1] = pack_point(127, 0, 1'b0);
      pts[2] = 16'hFFFF;
      pts[3] = 16'h0000;
      pts[4] = 16'h80FF;
      pts[5] = 16'h7F7F;
      program_curve(pts, 2, 0);
      send_request(mk_req(0, 1'b1));
      send_request(mk_req(-127, 1'b0));
      send_request(mk_req(126, 1'b0));
      idle_sender(1);
      wait_drained();

      // invalid curves: too few points, count past the maximum, bad percent, not rising
      pts[0] = pack_point(10, 10, 1'b0);
      pts[1] = pack_point(20, 20, 1'b0);
      pts[2] = pack_point(30, 30, 1'b0);
      pts[3] = pack_point(40, 40, 1'b0);
      pts[4] = pack_point(50, 50, 1'b0);
      pts[5] = pack_point(60, 60, 1'b0);
      program_curve(pts, 0, 5);
      send_request(mk_req(25, 1'b0));
      idle_sender(1);
      wait_drained();
      csr_write(fci_pkg::REG_POINT_COUNT, 32'd1);
      send_request(mk_req(25, 1'b1));
      idle_sender(1);
      wait_drained();
      csr_write(fci_pkg::REG_POINT_COUNT, 32'd7);
      send_request(mk_req(35, 1'b0));
      idle_sender(1);
      wait_drained();
      csr_write(fci_pkg::REG_POINT_COUNT, 32'd5);
      csr_write(EDIT_POINT, {16'h0, pack_point(40, 101, 1'b0)});
      send_request(mk_req(45, 1'b0));
      idle_sender(1);
      wait_drained();
      csr_write(EDIT_POINT, {16'h0, pack_point(30, 40, 1'b0)});
      send_request(mk_req(30, 1'b0));
      idle_sender(1);
      wait_drained();
      csr_write(EDIT_POINT, {16'h0, pack_point(25, 40, 1'b0)});
      send_request(mk_req(28, 1'b1));
      idle_sender(1);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         program_random_curve();
         // block fills up while the receiver holds off
         if (ph == 2) long_hold = 1'b1;
         run_random(PHASE_ITEMS);
         wait_drained();
      end

      waited = 0;
      while (book.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      book.check_drained();
      if (book.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/fci_pkg.sv
design/fci_regs.sv
design/fci_div.sv
design/fci_core.sv
design/fan_curve_interpolator_top.sv
dv/tb_fan_curve_interpolator_top.sv
